[rtl/qdd_pkg.sv]
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared widths, reset values and register indexes of the quadrature detent
// decoder.
// ----------------------------------------------------------------------------
package qdd_pkg;

	localparam int TIME_BITS_DEF     = 48;
	localparam int POSITION_BITS_DEF = 32;
	localparam int OUT_BITS          = 32;

	localparam int LOCKOUT_BITS = 20;
	localparam int TIMEOUT_BITS = 24;

	localparam logic [LOCKOUT_BITS-1:0] LOCKOUT_RESET = LOCKOUT_BITS'(5000);
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(100000);

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LOCKOUT = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT = CFG_INDEX_BITS'(1);

	typedef logic [1:0] phase_t;

endpackage

[rtl/qdd_in_if.sv]
// ----------------------------------------------------------------------------
// qdd_in_if
// Sample channel: one item per tick with both pin levels and the accumulate
// flag.
// ----------------------------------------------------------------------------
interface qdd_in_if;
	logic valid;
	logic ready;
	logic data_level;
	logic clock_level;
	logic accumulate;

	modport source (output valid, output data_level, output clock_level,
		output accumulate, input ready);
	modport sink (input valid, input data_level, input clock_level,
		input accumulate, output ready);
endinterface

[rtl/qdd_out_if.sv]
// ----------------------------------------------------------------------------
// qdd_out_if
// Result channel: one signed position item per tick.
// ----------------------------------------------------------------------------
interface qdd_out_if;
	import qdd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] position;

	modport source (output valid, output position, input ready);
	modport sink (input valid, input position, output ready);
endinterface

[rtl/qdd_cfg_if.sv]
// ----------------------------------------------------------------------------
// qdd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qdd_cfg_if;
	import qdd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/quadrature_detent_decoder.sv]
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while result.ready does not stall it; the
// whole tick update is one pass of logic from the input register into the
// state and result registers.
// Reset: valid bits and all state clear at once; input payload is not reset.
// Held pin levels reset high, lockout and timeout to 5000 and 100000 ticks.
// ----------------------------------------------------------------------------
// quadrature_detent_decoder
// Debounces the data and clock pins of a rotary encoder, stamps their edges
// with a tick count and turns the edge order into detent steps.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder #(
	parameter int TIME_BITS     = qdd_pkg::TIME_BITS_DEF,
	parameter int POSITION_BITS = qdd_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qdd_in_if.sink      sample,
	qdd_out_if.source   result,
	qdd_cfg_if.sink     cfg
);
	import qdd_pkg::*;

	// Input register.
	logic valid_s1;
	logic data_s1;
	logic clock_s1;
	logic acc_s1;

	// Result register valid; the payload is the position state itself.
	logic out_valid_q;

	// Configuration.
	logic [LOCKOUT_BITS-1:0] lockout_q;
	logic [TIMEOUT_BITS-1:0] timeout_q;

	// Decoder state.
	logic [TIME_BITS-1:0]     tick_q;
	logic [POSITION_BITS-1:0] pos_q;
	phase_t                   cw_q;
	phase_t                   ccw_q;
	logic [TIME_BITS-1:0]     phase_mark_q;
	logic [TIME_BITS-1:0]     dmark_q;
	logic [TIME_BITS-1:0]     cmark_q;
	logic [TIME_BITS-1:0]     dfall_q;
	logic [TIME_BITS-1:0]     drise_q;
	logic [TIME_BITS-1:0]     cfall_q;
	logic [TIME_BITS-1:0]     crise_q;
	logic                     d_held_q;
	logic                     c_held_q;

	// Next-state values.
	logic                     advance;
	logic [POSITION_BITS-1:0] pos_n;
	phase_t                   cw_n;
	phase_t                   ccw_n;
	logic [TIME_BITS-1:0]     phase_mark_n;
	logic [TIME_BITS-1:0]     dfall_n;
	logic [TIME_BITS-1:0]     drise_n;
	logic [TIME_BITS-1:0]     cfall_n;
	logic [TIME_BITS-1:0]     crise_n;
	logic                     d_take;
	logic                     c_take;
	logic                     d_n;
	logic                     c_n;
	logic                     timed_out;
	logic                     stepped;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	assign result.valid    = out_valid_q;
	assign result.position = OUT_BITS'(signed'(pos_q));

	assign timed_out = (tick_q - phase_mark_q) >= TIME_BITS'(timeout_q);
	assign d_take    = ((tick_q - dmark_q) >= TIME_BITS'(lockout_q)) && (data_s1 != d_held_q);
	assign c_take    = ((tick_q - cmark_q) >= TIME_BITS'(lockout_q)) && (clock_s1 != c_held_q);

	assign d_n     = d_take ? data_s1 : d_held_q;
	assign c_n     = c_take ? clock_s1 : c_held_q;
	assign dfall_n = (d_take && !data_s1) ? tick_q : dfall_q;
	assign drise_n = (d_take && data_s1) ? tick_q : drise_q;
	assign cfall_n = (c_take && !clock_s1) ? tick_q : cfall_q;
	assign crise_n = (c_take && clock_s1) ? tick_q : crise_q;

	always_comb begin
		phase_t                   cw0;
		phase_t                   ccw0;
		logic [POSITION_BITS-1:0] pos_base;
		cw0      = timed_out ? 2'd0 : cw_q;
		ccw0     = timed_out ? 2'd0 : ccw_q;
		pos_base = acc_s1 ? pos_q : '0;
		cw_n     = cw0;
		ccw_n    = ccw0;
		pos_n    = pos_base;
		stepped  = 1'b0;
		// The phase rules look at the held levels after this tick's samples.
		if (d_take || c_take) begin
			if (!d_n && c_n) begin
				if (dfall_n > crise_n) begin
					if (cw0 == 2'd0 && ccw0 == 2'd0) begin
						cw_n    = 2'd1;
						stepped = 1'b1;
					end
				end else if (crise_n > dfall_n) begin
					if (cw0 == 2'd0 && ccw0 == 2'd2) begin
						ccw_n   = 2'd3;
						stepped = 1'b1;
					end
				end
			end else if (d_n && !c_n) begin
				if (cfall_n > drise_n) begin
					if (cw0 == 2'd0 && ccw0 == 2'd0) begin
						ccw_n   = 2'd1;
						stepped = 1'b1;
					end
				end else if (drise_n > cfall_n) begin
					if (cw0 == 2'd2 && ccw0 == 2'd0) begin
						cw_n    = 2'd3;
						stepped = 1'b1;
					end
				end
			end else if (!d_n && !c_n) begin
				if (cfall_n > dfall_n) begin
					if (cw0 == 2'd1 && ccw0 == 2'd0) begin
						cw_n    = 2'd2;
						stepped = 1'b1;
					end
				end else if (dfall_n > cfall_n) begin
					if (cw0 == 2'd0 && ccw0 == 2'd1) begin
						ccw_n   = 2'd2;
						stepped = 1'b1;
					end
				end
			end else begin
				// Both pins back high: a detent completes.
				if (crise_n > drise_n) begin
					if (cw0 == 2'd3 && ccw0 == 2'd0) begin
						cw_n    = 2'd0;
						pos_n   = pos_base + POSITION_BITS'(1);
						stepped = 1'b1;
					end
				end else if (drise_n > crise_n) begin
					if (cw0 == 2'd0 && ccw0 == 2'd3) begin
						ccw_n   = 2'd0;
						pos_n   = pos_base - POSITION_BITS'(1);
						stepped = 1'b1;
					end
				end
			end
		end
		phase_mark_n = stepped ? tick_q : phase_mark_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			data_s1  <= sample.data_level;
			clock_s1 <= sample.clock_level;
			acc_s1   <= sample.accumulate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LOCKOUT: lockout_q <= cfg.data[LOCKOUT_BITS-1:0];
				REG_TIMEOUT: timeout_q <= cfg.data[TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			pos_q        <= '0;
			cw_q         <= 2'd0;
			ccw_q        <= 2'd0;
			phase_mark_q <= '0;
			dmark_q      <= '0;
			cmark_q      <= '0;
			dfall_q      <= '0;
			drise_q      <= '0;
			cfall_q      <= '0;
			crise_q      <= '0;
			d_held_q     <= 1'b1;
			c_held_q     <= 1'b1;
		end else if (advance) begin
			tick_q       <= tick_q + TIME_BITS'(1);
			pos_q        <= pos_n;
			cw_q         <= cw_n;
			ccw_q        <= ccw_n;
			phase_mark_q <= phase_mark_n;
			if (d_take) begin
				dmark_q <= tick_q;
			end
			if (c_take) begin
				cmark_q <= tick_q;
			end
			dfall_q      <= dfall_n;
			drise_q      <= drise_n;
			cfall_q      <= cfall_n;
			crise_q      <= crise_n;
			d_held_q     <= d_n;
			c_held_q     <= c_n;
		end
	end

	// A rotation is tracked in one direction at a time.
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		!(cw_q != 2'd0 && ccw_q != 2'd0))
		else $error("both phase counters are nonzero");

	a_tick_steps: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> tick_q == $past(tick_q) + TIME_BITS'(1))
		else $error("tick counter did not advance with the item");

	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !acc_s1) |=> (pos_q == '0 || pos_q == POSITION_BITS'(1) || pos_q == '1))
		else $error("non-accumulating item moved more than one detent");

	a_data_lockout: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (d_held_q == $past(d_held_q)) || (dmark_q == $past(tick_q)))
		else $error("data level changed without a new change mark");

	a_clock_lockout: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (c_held_q == $past(c_held_q)) || (cmark_q == $past(tick_q)))
		else $error("clock level changed without a new change mark");

endmodule
